@@ rtl/core/pmd_pkg.sv @@
// pmd_pkg: types, constants and the byte-wise crc function for the packet-mode deframer
// no dependencies; imported by packet_mode_deframer
package pmd_pkg;

  localparam int NUM_IDS = 4;
  localparam int POS_W = 9;

  localparam logic [15:0] CRC_PRESET  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_RESIDUE = 16'h1D0F;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // largest position the byte counter can reach (last crc byte at max length)
  localparam logic [POS_W-1:0] POS_MAX = 9'd257;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] packet_id;
    logic [7:0] payload_byte;
    logic       packet_ok;
    logic       continuity_error;
    logic       padding_error;
    logic       unit_restart;
    logic       unit_ready;
    logic       run_last;
  } result_t;

  // ccitt crc over one byte, msb first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

@@ rtl/core/packet_mode_deframer.sv @@
// packet_mode_deframer: header decode, crc check and per-id unit bookkeeping
// for a packet-mode byte stream; depends on pmd_pkg
//
// output: a byte's result is registered in the output register as the byte is taken
// throughput: one byte per cycle; each byte gives at most one result, and a byte is
// taken whenever the output register is empty or being emptied in the same cycle
// reset: clears position, per-id continuity and unit state, presets crc; packet_length goes to 1
module packet_mode_deframer (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  pmd_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output pmd_pkg::result_t result,
  input  logic             cfg_wr_en,
  input  logic [7:0]       cfg_wr_data
);
  import pmd_pkg::*;

  logic [7:0]       packet_length;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       header_latch, header_latch_next;
  logic [7:0]       useful_count, useful_count_next;
  logic [15:0]      running_crc, running_crc_next;
  logic             count_error, count_error_next;
  logic [2:0]       last_index [NUM_IDS];
  logic             unit_valid [NUM_IDS];
  logic [2:0]       last_index_next;
  logic             unit_valid_next;
  logic             table_wr;
  logic [1:0]       table_slot;

  logic             accept;
  logic             emit;
  result_t          res_next;

  logic [POS_W-1:0] p;
  logic [POS_W-1:0] len_ext;
  logic             pad, first, last;
  logic [1:0]       id;
  logic [2:0]       ci;
  logic [15:0]      crc_upd;
  logic             crc_ok;
  logic             cerr, pe, ready, uv;

  assign accept     = item_valid && item_ready;
  assign item_ready = !result_valid || result_ready;

  assign len_ext = {1'b0, packet_length};
  assign pad     = header_latch[3];
  assign first   = header_latch[7];
  assign last    = header_latch[6];
  assign id      = header_latch[5:4];
  assign ci      = header_latch[2:0];
  assign crc_upd = crc_byte(running_crc, item.data_byte);
  assign crc_ok  = (crc_upd == CRC_RESIDUE);

  // verdict bookkeeping for a packet whose crc passed
  always_comb begin
    cerr = ((last_index[id] + 3'd1) != ci);
    uv   = unit_valid[id];
    if (cerr) begin
      uv = 1'b0;
    end
    if (first) begin
      uv = 1'b1;
    end
    ready = last && uv;
    pe    = pad && count_error;
    if (pe) begin
      uv    = 1'b0;
      ready = 1'b0;
    end
    if (pad && first && last && (useful_count == 8'd0)) begin
      ready = 1'b0;
    end
    if (ready) begin
      uv = 1'b0;
    end
  end

  always_comb begin
    byte_position_next = byte_position;
    header_latch_next  = header_latch;
    useful_count_next  = useful_count;
    running_crc_next   = running_crc;
    count_error_next   = count_error;
    last_index_next    = ci;
    unit_valid_next    = uv;
    table_wr           = 1'b0;
    table_slot         = id;
    emit               = 1'b0;
    res_next           = '0;
    res_next.packet_id = id;
    res_next.run_last  = 1'b1;
    p                  = byte_position;

    if (item.frame_start && byte_position != '0) begin
      // realign mid-packet: failed verdict for the unfinished one
      emit          = 1'b1;
      res_next.kind = KIND_VERDICT;
      p             = '0;
    end

    if (p == '0) begin
      running_crc_next   = crc_byte(CRC_PRESET, item.data_byte);
      header_latch_next  = item.data_byte;
      useful_count_next  = 8'd0;
      count_error_next   = 1'b0;
      byte_position_next = 9'd1;
    end else begin
      running_crc_next = crc_upd;
      if (p <= len_ext) begin
        if (!pad) begin
          emit                  = 1'b1;
          res_next.kind         = KIND_BYTE;
          res_next.payload_byte = item.data_byte;
        end else if (p == 9'd1) begin
          useful_count_next = item.data_byte;
          count_error_next  = (item.data_byte >= packet_length);
        end else if (!count_error && ((p - 9'd2) < {1'b0, useful_count})) begin
          emit                  = 1'b1;
          res_next.kind         = KIND_BYTE;
          res_next.payload_byte = item.data_byte;
        end
        byte_position_next = p + 9'd1;
      end else if (p == len_ext + 9'd1) begin
        byte_position_next = p + 9'd1;
      end else begin
        emit               = 1'b1;
        res_next.kind      = KIND_VERDICT;
        byte_position_next = '0;
        if (crc_ok) begin
          table_wr                  = 1'b1;
          res_next.packet_ok        = 1'b1;
          res_next.continuity_error = cerr;
          res_next.padding_error    = pe;
          res_next.unit_restart     = first;
          res_next.unit_ready       = ready;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_length <= 8'd1;
      byte_position <= '0;
      header_latch  <= '0;
      useful_count  <= '0;
      running_crc   <= CRC_PRESET;
      count_error   <= 1'b0;
      result_valid  <= 1'b0;
      for (int i = 0; i < NUM_IDS; i++) begin
        last_index[i] <= '0;
        unit_valid[i] <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        packet_length <= cfg_wr_data;
      end
      if (accept) begin
        byte_position <= byte_position_next;
        header_latch  <= header_latch_next;
        useful_count  <= useful_count_next;
        running_crc   <= running_crc_next;
        count_error   <= count_error_next;
        if (table_wr) begin
          last_index[table_slot] <= last_index_next;
          unit_valid[table_slot] <= unit_valid_next;
        end
      end
      if (accept) begin
        result_valid <= emit;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result <= res_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_pos_range : assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_MAX)
    else $error("byte position out of range");

  a_realign_pos : assert property (@(posedge clk) disable iff (rst)
    accept && item.frame_start |=> byte_position == 9'd1)
    else $error("frame start did not realign to header");

  a_failed_clean : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_VERDICT && !result.packet_ok |->
      !result.continuity_error && !result.padding_error &&
      !result.unit_restart && !result.unit_ready)
    else $error("failed verdict carries flags");

  a_ready_not_padded_err : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.unit_ready |-> !result.padding_error && result.packet_ok)
    else $error("unit ready with padding error or failed crc");

  a_byte_clean : assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind == KIND_BYTE |-> !result.packet_ok && !result.unit_ready)
    else $error("tentative byte carries verdict flags");
`endif

endmodule

@@ tb/packet_mode_deframer_tb.sv @@
// packet_mode_deframer_tb: self-checking testbench for the packet-mode deframer
// builds packets with valid or broken crc, predicts every result and checks it
// depends on pmd_pkg and packet_mode_deframer
module packet_mode_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pmd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int WHOLE = 1000;

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;
  logic    cfg_wr_en;
  logic [7:0] cfg_wr_data;

  packet_mode_deframer uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // deframer state as predicted from the accepted bytes
  logic [8:0]  rx_pos;
  logic [7:0]  rx_header;
  logic [7:0]  rx_useful;
  logic [15:0] rx_crc;
  logic        rx_count_bad;
  logic [2:0]  id_last_ci [NUM_IDS];
  logic        id_unit_open [NUM_IDS];
  logic [7:0]  pkt_len;

  result_t expected_results [$];

  // continuity index the sender uses next for each id
  logic [2:0] next_ci [NUM_IDS];

  int fail_count = 0;
  int next_gap = 0;
  bit gaps_on = 1'b1;
  int hold_serial = 0;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc_update(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    repeat (8) r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    return r;
  endfunction

  function automatic logic [7:0] pack_header(input bit first, input bit last,
                                             input logic [1:0] id, input bit pad,
                                             input logic [2:0] ci);
    return {first, last, id, pad, ci};
  endfunction

  task automatic push_payload(input logic [7:0] b);
    result_t r;
    r = '0;
    r.kind = KIND_BYTE;
    r.packet_id = rx_header[5:4];
    r.payload_byte = b;
    expected_results.push_back(r);
  endtask

  task automatic push_verdict(input bit crc_ok);
    result_t r;
    logic [1:0] id;
    logic [2:0] ci;
    bit first, last, pad, cerr, perr, ready;
    id = rx_header[5:4];
    first = rx_header[7];
    last = rx_header[6];
    pad = rx_header[3];
    ci = rx_header[2:0];
    r = '0;
    r.kind = KIND_VERDICT;
    r.packet_id = id;
    // a failed packet leaves the per-id state alone
    if (crc_ok) begin
      cerr = (id_last_ci[id] + 3'd1) != ci;
      if (cerr) id_unit_open[id] = 1'b0;
      id_last_ci[id] = ci;
      if (first) id_unit_open[id] = 1'b1;
      ready = last && id_unit_open[id];
      perr = pad && rx_count_bad;
      if (perr) begin
        id_unit_open[id] = 1'b0;
        ready = 1'b0;
      end
      // padded single-packet unit with nothing in it
      if (pad && first && last && rx_useful == 8'd0) ready = 1'b0;
      if (ready) id_unit_open[id] = 1'b0;
      r.packet_ok = 1'b1;
      r.continuity_error = cerr;
      r.padding_error = perr;
      r.unit_restart = first;
      r.unit_ready = ready;
    end
    expected_results.push_back(r);
  endtask

  task automatic deframe_predict(input logic [7:0] b, input logic fs);
    int n0;
    result_t r;
    n0 = expected_results.size();
    if (fs && rx_pos != 9'd0) begin
      push_verdict(1'b0);
      rx_pos = 9'd0;
    end
    if (rx_pos == 9'd0) begin
      rx_crc = crc_update(CRC_PRESET, b);
      rx_header = b;
      rx_useful = 8'd0;
      rx_count_bad = 1'b0;
      rx_pos = 9'd1;
    end else begin
      rx_crc = crc_update(rx_crc, b);
      if (rx_pos <= pkt_len) begin
        if (!rx_header[3]) begin
          push_payload(b);
        end else if (rx_pos == 9'd1) begin
          rx_useful = b;
          rx_count_bad = b >= pkt_len;
        end else if (!rx_count_bad && rx_pos - 2 < rx_useful) begin
          push_payload(b);
        end
        rx_pos = rx_pos + 9'd1;
      end else if (rx_pos == pkt_len + 1) begin
        rx_pos = rx_pos + 9'd1;
      end else begin
        push_verdict(rx_crc == CRC_RESIDUE);
        rx_pos = 9'd0;
      end
    end
    if (expected_results.size() > n0) begin
      r = expected_results.pop_back();
      r.run_last = 1'b1;
      expected_results.push_back(r);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fs);
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    item_valid <= 1'b1;
    item <= '{data_byte: b, frame_start: fs};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    deframe_predict(b, fs);
    // valid stays up when the next request follows at once
    next_gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (next_gap > 0) item_valid <= 1'b0;
  endtask

  task automatic drain();
    if (next_gap == 0) item_valid <= 1'b0;
    next_gap = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_length(input logic [7:0] len);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pkt_len = len;
    @(posedge clk);
  endtask

  // header, data field (count byte first when padded), inverted crc high byte first
  task automatic send_packet(input logic [7:0] header, input logic [7:0] count,
                             input bit bad_crc, input int keep);
    logic [7:0] bytes [$];
    logic [15:0] c;
    logic fs;
    int idx;
    bytes.push_back(header);
    for (int i = 0; i < pkt_len; i++)
      bytes.push_back((header[3] && i == 0) ? count : 8'($urandom));
    c = CRC_PRESET;
    foreach (bytes[i]) c = crc_update(c, bytes[i]);
    c = ~c;
    bytes.push_back(c[15:8]);
    bytes.push_back(c[7:0]);
    if (bad_crc) begin
      idx = $urandom_range(0, bytes.size() - 1);
      bytes[idx] = bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
    end
    next_ci[header[5:4]] = header[2:0] + 3'd1;
    for (int i = 0; i < bytes.size() && i < keep; i++) begin
      if (i == 0) fs = (rx_pos != 9'd0) ? 1'b1 : 1'($urandom_range(0, 1));
      else fs = 1'b0;
      send_byte(bytes[i], fs);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      $error("result with none expected: kind %0d id %0d byte %0h",
             got.kind, got.packet_id, got.payload_byte);
      fail_count++;
      return;
    end
    want = expected_results.pop_front();
    check_field("kind", 8'(want.kind), 8'(got.kind));
    check_field("packet_id", 8'(want.packet_id), 8'(got.packet_id));
    check_field("payload_byte", want.payload_byte, got.payload_byte);
    check_field("packet_ok", 8'(want.packet_ok), 8'(got.packet_ok));
    check_field("continuity_error", 8'(want.continuity_error), 8'(got.continuity_error));
    check_field("padding_error", 8'(want.padding_error), 8'(got.padding_error));
    check_field("unit_restart", 8'(want.unit_restart), 8'(got.unit_restart));
    check_field("unit_ready", 8'(want.unit_ready), 8'(got.unit_ready));
    check_field("run_last", 8'(want.run_last), 8'(got.run_last));
  endtask

  // result side: random stalls per request plus an occasional long hold
  initial begin : result_sink
    int stall_left;
    int hold_left;
    int hold_seen;
    stall_left = 0;
    hold_left = 0;
    hold_seen = 0;
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && result_ready) begin
        check_result(result);
        stall_left = gaps_on ? $urandom_range(0, 3) : 0;
      end
      if (hold_seen != hold_serial) begin
        hold_seen = hold_serial;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic run_random(input int packets);
    logic [1:0] id;
    logic [2:0] ci;
    logic [7:0] count;
    logic [7:0] hdr;
    int roll;
    for (int k = 0; k < packets; k++) begin
      if (k % 12 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      if (k == packets / 2) drain();
      id = 2'($urandom_range(0, 3));
      ci = ($urandom_range(0, 11) == 0) ? 3'($urandom) : next_ci[id];
      roll = $urandom_range(0, 9);
      count = (roll == 0) ? pkt_len :
              (roll == 1) ? 8'($urandom_range(pkt_len, 255)) :
                            8'($urandom_range(0, pkt_len - 1));
      hdr = pack_header($urandom_range(0, 2) == 0, $urandom_range(0, 2) == 0, id,
                        $urandom_range(0, 1) == 1, ci);
      roll = $urandom_range(0, 99);
      if (roll < 88) begin
        send_packet(hdr, count, 1'b0, WHOLE);
      end else if (roll < 94) begin
        send_packet(hdr, count, 1'b1, WHOLE);
      end else if (roll < 97) begin
        // cut short, the next header realigns
        send_packet(hdr, count, 1'b0, $urandom_range(1, pkt_len + 2));
      end else begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end
    end
    drain();
  endtask

  // length 1 after reset: unit flags, continuity, padding, bad crc, realign
  task automatic test_unit_flags();
    send_packet(pack_header(1'b1, 1'b0, 2'd0, 1'b0, 3'd1), 8'd0, 1'b0, WHOLE);
    send_packet(pack_header(1'b0, 1'b1, 2'd0, 1'b0, 3'd2), 8'd0, 1'b0, WHOLE);
    send_packet(pack_header(1'b0, 1'b1, 2'd0, 1'b0, 3'd3), 8'd0, 1'b0, WHOLE);
    send_packet(8'h00, 8'd0, 1'b0, WHOLE);
    send_packet(8'hFF, 8'd0, 1'b0, WHOLE);
    send_packet(pack_header(1'b1, 1'b1, 2'd1, 1'b1, 3'd1), 8'd255, 1'b0, WHOLE);
    send_packet(pack_header(1'b1, 1'b1, 2'd2, 1'b1, 3'd1), 8'd1, 1'b0, WHOLE);
    send_packet(pack_header(1'b1, 1'b1, 2'd2, 1'b0, 3'd2), 8'd0, 1'b1, WHOLE);
    send_packet(pack_header(1'b1, 1'b0, 2'd1, 1'b0, 3'd2), 8'd0, 1'b0, 2);
    send_packet(pack_header(1'b1, 1'b1, 2'd1, 1'b0, 3'd2), 8'd0, 1'b0, WHOLE);
    drain();
  endtask

  // empty data field: header then crc
  task automatic test_zero_length();
    set_length(8'd0);
    send_packet(pack_header(1'b1, 1'b1, 2'd0, 1'b0, next_ci[0]), 8'd0, 1'b0, WHOLE);
    send_packet(pack_header(1'b1, 1'b1, 2'd3, 1'b1, next_ci[3]), 8'd0, 1'b0, WHOLE);
    drain();
  endtask

  // length rewritten while a packet is half way through
  task automatic test_length_change();
    set_length(8'd6);
    send_packet(pack_header(1'b1, 1'b0, 2'd2, 1'b0, next_ci[2]), 8'd0, 1'b0, 5);
    drain();
    set_length(8'd2);
    send_byte(8'($urandom), 1'b0);
    drain();
    send_packet(pack_header(1'b0, 1'b1, 2'd2, 1'b0, next_ci[2]), 8'd0, 1'b0, 3);
    drain();
    set_length(8'd10);
    repeat (10) send_byte(8'($urandom), 1'b0);
    drain();
  endtask

  task automatic test_random_traffic();
    set_length(8'd3);
    run_random(40);
    repeat (3) begin
      set_length(8'($urandom_range(2, 20)));
      run_random(12);
    end
    set_length(8'd1);
    run_random(40);
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    set_length(8'd8);
    hold_serial <= hold_serial + 1;
    run_random(30);
  endtask

  task automatic test_long_packets();
    set_length(8'd255);
    gaps_on = 1'b0;
    send_packet(pack_header(1'b1, 1'b1, 2'd0, 1'b1, next_ci[0]), 8'd254, 1'b0, WHOLE);
    run_random(1);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 8'd0;
    rx_pos = 9'd0;
    rx_header = 8'd0;
    rx_useful = 8'd0;
    rx_crc = CRC_PRESET;
    rx_count_bad = 1'b0;
    pkt_len = 8'd1;
    for (int i = 0; i < NUM_IDS; i++) begin
      id_last_ci[i] = 3'd0;
      id_unit_open[i] = 1'b0;
      next_ci[i] = 3'd1;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unit_flags();
    test_zero_length();
    test_length_change();
    test_random_traffic();
    test_backpressure();
    test_long_packets();

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/pmd_pkg.sv
rtl/core/packet_mode_deframer.sv
tb/packet_mode_deframer_tb.sv
